// ===== hw/rtl/lasu_pkg.sv =====
// ----------------------------------------------------------------------------
// lasu_pkg
// Shared types, widths and fixed-point helpers for the state update block.
// ----------------------------------------------------------------------------
package lasu_pkg;

  localparam int HEADS_DEF     = 4;
  localparam int HEAD_SIZE_DEF = 64;

  localparam int SUM_W = 56;
  localparam int P_W   = 42;
  localparam int PL_W  = 21;
  localparam int C_W   = 21;
  localparam int ACC_W = 64;

  localparam logic signed [ACC_W-1:0] SAT_MAX = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic [1:0]         head;
    logic [5:0]         elem_index;
    logic signed [15:0] r_value;
    logic [15:0]        w_value;
    logic signed [15:0] k_value;
    logic signed [15:0] v_value;
    logic [15:0]        a_value;
    logic signed [15:0] kk_value;
    logic               last_elem;
  } in_t;

  typedef struct packed {
    logic [1:0]         out_head;
    logic [5:0]         out_index;
    logic signed [31:0] out_value;
    logic               out_last;
  } out_t;

  typedef struct packed {
    logic load_s;
    logic load_pk;
    logic mult;
    logic add1;
    logic add2;
    logic sat;
    logic load_pr;
  } ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [31:0] y;
    if (x > SAT_MAX) begin
      y = 32'sh7fff_ffff;
    end else if (x < SAT_MIN) begin
      y = 32'sh8000_0000;
    end else begin
      y = x[31:0];
    end
    return y;
  endfunction

  function automatic logic signed [ACC_W-1:0] rnd12(input logic signed [ACC_W-1:0] x);
    return (x + 64'sd2048) >>> 12;
  endfunction

  function automatic logic signed [ACC_W-1:0] rnd16(input logic signed [ACC_W-1:0] x);
    return (x + 64'sd32768) >>> 16;
  endfunction

endpackage

// ===== hw/rtl/linear_attention_state_update.sv =====
// rows: a head update with read-out handles the HEAD_SIZE rows of the head one
// after another, and a row waits in read-out while the output is stalled
// throughput: while the block is idle, element items without the last mark are
// taken one per cycle; the row sum chain through the cells sets the per-row time
// reset: synchronous; afterwards a clearing pass over all HEADS*HEAD_SIZE state
// rows zeroes them, during which input is stalled
// ----------------------------------------------------------------------------
// linear_attention_state_update
// Per-head state matrix update and read-out over a chain of column cells.
// ----------------------------------------------------------------------------
module linear_attention_state_update import lasu_pkg::*; #(
  parameter int HEADS     = HEADS_DEF,
  parameter int HEAD_SIZE = HEAD_SIZE_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int ROWS  = HEADS * HEAD_SIZE;
  localparam int AW    = $clog2(ROWS);
  localparam int ROW_W = $clog2(HEAD_SIZE);
  localparam int CW    = $clog2(HEAD_SIZE + 1);
  localparam int RW    = HEAD_SIZE * 32;

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_RD   = 4'd2;
  localparam logic [3:0] ST_LD   = 4'd3;
  localparam logic [3:0] ST_PK   = 4'd4;
  localparam logic [3:0] ST_PSUM = 4'd5;
  localparam logic [3:0] ST_PRND = 4'd6;
  localparam logic [3:0] ST_MUL  = 4'd7;
  localparam logic [3:0] ST_ADD1 = 4'd8;
  localparam logic [3:0] ST_ADD2 = 4'd9;
  localparam logic [3:0] ST_SAT  = 4'd10;
  localparam logic [3:0] ST_PR   = 4'd11;
  localparam logic [3:0] ST_OSUM = 4'd12;
  localparam logic [3:0] ST_OUT  = 4'd13;

  logic [3:0]             state;
  logic [AW-1:0]          clr_addr;
  logic [CW-1:0]          cnt;
  logic [ROW_W-1:0]       row;
  logic [1:0]             head_q;
  logic signed [P_W-1:0]  p;
  logic signed [15:0]     v_q;
  logic [RW-1:0]          mem_q;
  logic [RW-1:0]          smem [ROWS];
  logic signed [15:0]     vmem [HEAD_SIZE];

  logic                   accept, idx_ok, head_ok, wr, row_last, out_load;
  logic [AW-1:0]          addr;
  logic [RW-1:0]          row_new;
  ctl_t                   ctl;
  logic signed [SUM_W-1:0] chain [HEAD_SIZE+1];

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign idx_ok   = 7'(in_data.elem_index) < 7'(HEAD_SIZE);
  assign head_ok  = 7'(in_data.head) < 7'(HEADS);
  assign wr       = accept && idx_ok;
  assign row_last = (row == ROW_W'(HEAD_SIZE - 1));
  assign addr     = AW'(head_q) * AW'(HEAD_SIZE) + AW'(row);
  assign out_load = (state == ST_OUT) && (!out_valid || !out_stall);

  always_comb begin
    ctl.load_s  = (state == ST_LD);
    ctl.load_pk = (state == ST_PK);
    ctl.mult    = (state == ST_MUL);
    ctl.add1    = (state == ST_ADD1);
    ctl.add2    = (state == ST_ADD2);
    ctl.sat     = (state == ST_SAT);
    ctl.load_pr = (state == ST_PR);
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < HEAD_SIZE; g++) begin : g_cell
    lasu_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .wr      (wr),
      .din     (in_data),
      .ctl     (ctl),
      .s_in    (mem_q[g*32 +: 32]),
      .p       (p),
      .v       (v_q),
      .sum_in  (chain[g]),
      .sum_out (chain[g+1]),
      .s_out   (row_new[g*32 +: 32])
    );
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLR) begin
      smem[clr_addr] <= '0;
    end else if (state == ST_PR) begin
      smem[addr] <= row_new;
    end
    if (state == ST_RD) begin
      mem_q <= smem[addr];
      v_q   <= vmem[row];
    end
    if (wr) begin
      vmem[in_data.elem_index[ROW_W-1:0]] <= in_data.v_value;
    end
    if (state == ST_PRND) begin
      p <= P_W'(rnd12(ACC_W'(chain[HEAD_SIZE])));
    end
    if (out_load) begin
      out_data.out_head  <= head_q;
      out_data.out_index <= 6'(row);
      out_data.out_value <= sat32(rnd12(ACC_W'(chain[HEAD_SIZE])));
      out_data.out_last  <= row_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_addr  <= '0;
      cnt       <= '0;
      row       <= '0;
      head_q    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(ROWS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && in_data.last_elem && head_ok) begin
            head_q <= in_data.head;
            row    <= '0;
            state  <= ST_RD;
          end
        end
        ST_RD:   state <= ST_LD;
        ST_LD:   state <= ST_PK;
        ST_PK: begin
          cnt   <= '0;
          state <= ST_PSUM;
        end
        ST_PSUM: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(HEAD_SIZE - 1)) begin
            state <= ST_PRND;
          end
        end
        ST_PRND: state <= ST_MUL;
        ST_MUL:  state <= ST_ADD1;
        ST_ADD1: state <= ST_ADD2;
        ST_ADD2: state <= ST_SAT;
        ST_SAT:  state <= ST_PR;
        ST_PR: begin
          cnt   <= '0;
          state <= ST_OSUM;
        end
        ST_OSUM: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(HEAD_SIZE - 1)) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            if (row_last) begin
              state <= ST_IDLE;
            end else begin
              row   <= row + ROW_W'(1);
              state <= ST_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/lasu_cell.sv =====
// ----------------------------------------------------------------------------
// lasu_cell
// One column of the head state: element buffers, the state word of the
// current row, the update arithmetic and one stage of the row sum chain.
// ----------------------------------------------------------------------------
module lasu_cell import lasu_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  logic                    wr,
  input  in_t                     din,
  input  ctl_t                    ctl,
  input  logic signed [31:0]      s_in,
  input  logic signed [P_W-1:0]   p,
  input  logic signed [15:0]      v,
  input  logic signed [SUM_W-1:0] sum_in,
  output logic signed [SUM_W-1:0] sum_out,
  output logic signed [31:0]      s_out
);

  logic signed [15:0]      r, k, kk;
  logic [15:0]             w, a;
  logic signed [31:0]      s;
  logic signed [C_W-1:0]   c;
  logic signed [47:0]      prod;
  logic signed [48:0]      m1;
  logic signed [41:0]      mh;
  logic signed [42:0]      ml;
  logic signed [31:0]      m3;
  logic signed [ACC_W-1:0] t1, t2, acc;
  logic signed [SUM_W-1:0] sum;

  logic signed [32:0]      kka;
  logic signed [47:0]      skk, sr;
  logic signed [48:0]      sw;
  logic signed [PL_W-1:0]  ph;
  logic signed [PL_W:0]    pl;

  assign kka = kk * $signed({1'b0, a});
  assign skk = s * kk;
  assign sr  = s * r;
  assign sw  = s * $signed({1'b0, w});
  assign ph  = $signed(p[P_W-1:PL_W]);
  assign pl  = $signed({1'b0, p[PL_W-1:0]});

  always_ff @(posedge clk) begin
    if (wr && din.elem_index == 6'(IDX)) begin
      r  <= din.r_value;
      w  <= din.w_value;
      k  <= din.k_value;
      a  <= din.a_value;
      kk <= din.kk_value;
    end
    if (ctl.load_s) begin
      s <= s_in;
    end else if (ctl.sat) begin
      s <= sat32(rnd16(acc));
    end
    if (ctl.load_pk) begin
      prod <= skk;
      c    <= C_W'(rnd12(ACC_W'(kka)));
    end else if (ctl.load_pr) begin
      prod <= sr;
    end
    if (ctl.mult) begin
      m1 <= sw;
      mh <= ph * c;
      ml <= pl * c;
      m3 <= v * k;
    end
    if (ctl.add1) begin
      t1 <= ACC_W'(m1) + (ACC_W'(m3) <<< 8);
      t2 <= (ACC_W'(mh) <<< PL_W) + ACC_W'(ml);
    end
    if (ctl.add2) begin
      acc <= t1 - t2;
    end
    sum <= sum_in + SUM_W'(prod);
  end

  assign sum_out = sum;
  assign s_out   = s;

endmodule

// ===== hw/rtl/lasu_checker.sv =====
// ----------------------------------------------------------------------------
// lasu_checker
// Port-level properties of the state update block, bound to the top level.
// ----------------------------------------------------------------------------
module lasu_checker import lasu_pkg::*; #(
  parameter int HEADS     = HEADS_DEF,
  parameter int HEAD_SIZE = HEAD_SIZE_DEF
) (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled after reset");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.out_last |-> out_data.out_index == 6'(HEAD_SIZE - 1))
    else $error("last read-out on wrong row");

  // update request blocks further input
  a_busy_after_update: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.last_elem && (7'(in_data.head) < 7'(HEADS))
    |=> in_stall)
    else $error("input taken during update");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind linear_attention_state_update lasu_checker #(
  .HEADS     (HEADS),
  .HEAD_SIZE (HEAD_SIZE)
) u_lasu_checker (.*);

// ===== dv/linear_attention_state_update_tb.sv =====
// ----------------------------------------------------------------------------
// linear_attention_state_update_tb
// Checks the per-head state update and read-out. Element requests are sent
// with random gaps while the output side stalls at random, but for a last calm
// run with neither. A predictor in the bench mirrors the state matrix and the
// element buffers. Every read-out row is compared field by field with the oldest predicted row.
// ----------------------------------------------------------------------------
module linear_attention_state_update_tb;
  import lasu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NH = 4;
  localparam int NS = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  linear_attention_state_update DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  int              head_state [NH][NS][NS];
  logic [15:0]     r_buf [NS], w_buf [NS], k_buf [NS], v_buf [NS], a_buf [NS], kk_buf [NS];
  out_t            readout_rows [$];
  int              mismatches = 0;
  int              requests_sent = 0;
  int              rows_checked = 0;
  int              updates_run = 0;
  bit              calm = 1'b0;
  int              stall_left = 0;

  initial forever #6 clk = ~clk;

  initial begin
    #200ms;
    $display("** linear_attention_state_update: FAILED **");
    $finish;
  end

  function automatic longint round_shift(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic int clamp32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fff_ffff;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return int'(x);
  endfunction

  function automatic longint sv16(logic [15:0] x);
    return longint'($signed(x));
  endfunction

  // store the element, and on the last mark update the head and queue rows
  task automatic update_head(in_t d);
    longint c [NS];
    longint p, acc, ro;
    out_t   row;
    int     h;
    h = int'(d.head);
    r_buf[d.elem_index]  = d.r_value;
    w_buf[d.elem_index]  = d.w_value;
    k_buf[d.elem_index]  = d.k_value;
    v_buf[d.elem_index]  = d.v_value;
    a_buf[d.elem_index]  = d.a_value;
    kk_buf[d.elem_index] = d.kk_value;
    if (!d.last_elem || h >= NH) return;
    updates_run++;
    for (int j = 0; j < NS; j++) c[j] = round_shift(sv16(kk_buf[j]) * longint'(a_buf[j]), 12);
    for (int i = 0; i < NS; i++) begin
      p = 0;
      for (int m = 0; m < NS; m++) p += longint'(head_state[h][i][m]) * sv16(kk_buf[m]);
      p = round_shift(p, 12);
      ro = 0;
      for (int j = 0; j < NS; j++) begin
        acc = longint'(head_state[h][i][j]) * longint'(w_buf[j]);
        acc -= p * c[j];
        acc += sv16(v_buf[i]) * sv16(k_buf[j]) * 256;
        head_state[h][i][j] = clamp32(round_shift(acc, 16));
        ro += longint'(head_state[h][i][j]) * sv16(r_buf[j]);
      end
      row.out_head  = d.head;
      row.out_index = i[5:0];
      row.out_value = clamp32(round_shift(ro, 12));
      row.out_last  = (i == NS - 1);
      readout_rows.push_back(row);
    end
  endtask

  task automatic send_request(in_t d);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    update_head(d);
    requests_sent++;
  endtask

  function automatic in_t random_elem(logic [1:0] h, logic [5:0] idx, logic last);
    in_t d;
    d.head       = h;
    d.elem_index = idx;
    d.r_value    = 16'($urandom);
    d.w_value    = ($urandom_range(0, 1) != 0) ? (16'hf000 | 16'($urandom)) : 16'($urandom);
    d.k_value    = 16'($urandom);
    d.v_value    = 16'($urandom);
    d.a_value    = 16'($urandom);
    d.kk_value   = 16'($urandom);
    d.last_elem  = last;
    return d;
  endfunction

  task automatic send_token(logic [1:0] h, int len, bit full);
    for (int n = 0; n < len; n++)
      send_request(random_elem(h, full ? n[5:0] : 6'($urandom), n == len - 1));
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("mismatch %s: got %0d expected %0d (row %0d)", what, got, want, rows_checked);
  endtask

  always @(posedge clk) begin
    if (!calm && stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(negedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (readout_rows.size() == 0) begin
        report_mismatch("unexpected row, head", out_data.out_head, -1);
      end else begin
        want = readout_rows.pop_front();
        if (out_data.out_head !== want.out_head)
          report_mismatch("out_head", out_data.out_head, want.out_head);
        if (out_data.out_index !== want.out_index)
          report_mismatch("out_index", out_data.out_index, want.out_index);
        if (out_data.out_value !== want.out_value)
          report_mismatch("out_value", out_data.out_value, want.out_value);
        if (out_data.out_last !== want.out_last)
          report_mismatch("out_last", out_data.out_last, want.out_last);
      end
      rows_checked++;
    end
  end

  // every buffer entry gets written before the first update
  task automatic test_fill_extremes();
    in_t d;
    for (int j = 0; j < NS; j++) begin
      d = random_elem(2'd0, j[5:0], j == NS - 1);
      case (j % 4)
        0: begin
          d.r_value = 16'sh7fff; d.k_value = 16'sh7fff; d.v_value = 16'sh7fff;
          d.kk_value = 16'sh7fff; d.w_value = 16'hffff; d.a_value = 16'hffff;
        end
        1: begin
          d.r_value = 16'sh8000; d.k_value = 16'sh8000; d.v_value = 16'sh8000;
          d.kk_value = 16'sh8000; d.w_value = 16'h0000; d.a_value = 16'h0000;
        end
        2: begin
          d.r_value = '0; d.k_value = '0; d.v_value = '0; d.kk_value = '0;
        end
        default: d.w_value = 16'h8000;
      endcase
      send_request(d);
    end
  endtask

  // repeated growth with full decay drives state and read-out into saturation
  task automatic test_saturation();
    in_t d;
    for (int n = 0; n < 6; n++) begin
      d = '{head: 2'd3, elem_index: 6'd0, r_value: 16'sh7fff, w_value: 16'hffff,
            k_value: 16'sh7fff, v_value: 16'sh7fff, a_value: 16'h0000,
            kk_value: 16'sh0000, last_elem: 1'b1};
      send_request(d);
    end
  endtask

  // strongest in-context correction on every head
  task automatic test_each_head();
    in_t d;
    for (int h = 0; h < NH; h++) begin
      d = random_elem(h[1:0], 6'(h * 17), 1'b1);
      d.a_value  = 16'hffff;
      d.kk_value = 16'sh8000;
      send_request(d);
    end
  endtask

  task automatic test_random_tokens();
    while (requests_sent < 250) begin
      if ($urandom_range(0, 3) != 0)
        send_token(2'($urandom), $urandom_range(1, NS), 1'b0);
      else
        send_request(random_elem(2'($urandom), 6'($urandom), $urandom_range(0, 9) == 0));
    end
  endtask

  task automatic test_no_idling();
    calm = 1'b1;
    send_token(2'($urandom), NS, 1'b1);
    send_token(2'($urandom), $urandom_range(1, 8), 1'b0);
  endtask

  initial begin
    for (int h = 0; h < NH; h++)
      for (int i = 0; i < NS; i++)
        for (int j = 0; j < NS; j++) head_state[h][i][j] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_extremes();
    test_saturation();
    test_each_head();
    test_random_tokens();
    test_no_idling();
    in_valid <= 1'b0;
    while (readout_rows.size() != 0) @(posedge clk);
    repeat (2 * NS + 20) @(posedge clk);
    $display("sent %0d element requests, ran %0d head updates, checked %0d rows",
             requests_sent, updates_run, rows_checked);
    if (mismatches == 0) begin
      $display("** linear_attention_state_update: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** linear_attention_state_update: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lasu_pkg.sv
hw/rtl/lasu_cell.sv
hw/rtl/linear_attention_state_update.sv
hw/rtl/lasu_checker.sv
dv/linear_attention_state_update_tb.sv
